// ===== rtl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the divider step for the rgb to hsl pipeline
// no dependencies

package rgbhsl_pkg;

    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 9;
    localparam int DIV_W       = 16;
    localparam int QUO_W       = 8;
    localparam int HUE_Q_W     = 6;
    localparam int DIV_STAGES  = 4;

    localparam logic [SUM_W-1:0] HUE_BASE_RED    = 9'd0;
    localparam logic [SUM_W-1:0] HUE_BASE_WRAP   = 9'd360;
    localparam logic [SUM_W-1:0] HUE_BASE_GREEN  = 9'd120;
    localparam logic [SUM_W-1:0] HUE_BASE_BLUE   = 9'd240;
    localparam logic [SUM_W-1:0] SUM_FULL        = 9'd510;
    localparam logic [SUM_W-1:0] SUM_HALF        = 9'd255;

    // partial remainder, divisor aligned to the next quotient bit, quotient so far
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
    } div_state_t;

    typedef struct packed {
        div_state_t       sat;
        div_state_t       hue;
        logic [SUM_W-1:0] base;
        logic             neg;
        logic [SUM_W-1:0] lsum;
    } pipe_t;

    // one restoring step: compare, subtract, shift the divisor down
    function automatic div_state_t div_step(input div_state_t st);
        div_state_t nx;
        nx = st;
        if (st.rem >= st.dsh)
        begin
            nx.rem = st.rem - st.dsh;
            nx.quo = {st.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            nx.quo = {st.quo[QUO_W-2:0], 1'b0};
        end
        nx.dsh = {1'b0, st.dsh[DIV_W-1:1]};
        return nx;
    endfunction

endpackage

// ===== rtl/rgbhsl_div_stage.sv =====
`timescale 1ns / 1ps
// one elastic pipeline stage doing two restoring steps on both quotients
// depends on rgbhsl_pkg

module rgbhsl_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rgbhsl_pkg::pipe_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rgbhsl_pkg::pipe_t  out_data
);

    logic              valid_reg;
    rgbhsl_pkg::pipe_t data_reg;
    rgbhsl_pkg::pipe_t data_next;

    always_comb
    begin
        data_next     = in_data;
        data_next.sat = rgbhsl_pkg::div_step(rgbhsl_pkg::div_step(in_data.sat));
        data_next.hue = rgbhsl_pkg::div_step(rgbhsl_pkg::div_step(in_data.hue));
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/rgb_to_hsl_converter_top.sv =====
`timescale 1ns / 1ps
// rgb to hsl converter, top level: channel sort, numerators, divider chain, hue fixup
// depends on rgbhsl_pkg and rgbhsl_div_stage

// usage
//   input channel: in_valid / in_ready carry one pixel (red, green, blue) per request
//   output channel: out_valid / out_ready carry hue_deg, saturation, lightness_sum
//   lightness_sum is max + min channel; saturation is scaled by 255; hue in whole degrees
//   gray pixels give hue 0 and saturation 0
// timing
//   seven register stages: channel sort, numerator build, four divider stages with
//   two quotient bits each, and the hue fixup stage that is also the output register
//   throughput is one pixel per cycle while out_ready stays high; the two restoring dividers are fully pipelined
// flow control
//   every stage has its own valid bit and takes a new request whenever it is empty
//   or its content moves on, so bubbles are squeezed out while the output stalls
//   in_ready falls only when all seven stages hold requests and out_ready is low
// reset
//   rst_n clears all valid bits; no pixel state is kept between requests

module rgb_to_hsl_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [8:0] hue_deg,
    output logic [7:0] saturation,
    output logic [8:0] lightness_sum
);

    // sort stage payload
    typedef struct packed {
        logic [7:0] dv;     // max - min, forced to 1 for gray
        logic [7:0] den;    // saturation divisor, forced to 1 for gray
        logic [7:0] mag;    // magnitude of the hue channel difference
        logic [8:0] base;
        logic       neg;
        logic [8:0] lsum;
    } sort_t;

    // ---------------- stage 1: channel sort ----------------
    logic       sort_valid_reg;
    logic       sort_ready;
    sort_t      sort_reg;
    sort_t      sort_next;

    logic       r_max;
    logic       g_max;
    logic [7:0] mx;
    logic [7:0] mn;
    logic [7:0] d;
    logic [8:0] s;
    logic [8:0] s_inv;

    always_comb
    begin
        r_max = (red >= green) && (red >= blue);
        g_max = !r_max && (green >= blue);

        if (r_max)
        begin
            mx = red;
        end
        else if (g_max)
        begin
            mx = green;
        end
        else
        begin
            mx = blue;
        end

        if ((red <= green) && (red <= blue))
        begin
            mn = red;
        end
        else if (green <= blue)
        begin
            mn = green;
        end
        else
        begin
            mn = blue;
        end

        d     = mx - mn;
        s     = {1'b0, mx} + {1'b0, mn};
        s_inv = rgbhsl_pkg::SUM_FULL - s;

        sort_next.lsum = s;
        sort_next.dv   = (d == 8'd0) ? 8'd1 : d;
        if (d == 8'd0)
        begin
            sort_next.den = 8'd1;
        end
        else if (s <= rgbhsl_pkg::SUM_HALF)
        begin
            sort_next.den = s[7:0];
        end
        else
        begin
            sort_next.den = s_inv[7:0];
        end

        // gray lands in the red arm with a zero difference
        if (r_max)
        begin
            sort_next.neg  = green < blue;
            sort_next.mag  = (green < blue) ? (blue - green) : (green - blue);
            sort_next.base = (green < blue) ? rgbhsl_pkg::HUE_BASE_WRAP
                                            : rgbhsl_pkg::HUE_BASE_RED;
        end
        else if (g_max)
        begin
            sort_next.neg  = blue < red;
            sort_next.mag  = (blue < red) ? (red - blue) : (blue - red);
            sort_next.base = rgbhsl_pkg::HUE_BASE_GREEN;
        end
        else
        begin
            sort_next.neg  = red < green;
            sort_next.mag  = (red < green) ? (green - red) : (red - green);
            sort_next.base = rgbhsl_pkg::HUE_BASE_BLUE;
        end
    end

    assign in_ready = !sort_valid_reg || sort_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            sort_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sort_reg <= sort_next;
        end
    end

    // ---------------- stage 2: numerators and divider setup ----------------
    logic              num_valid_reg;
    logic              num_ready;
    rgbhsl_pkg::pipe_t num_reg;
    rgbhsl_pkg::pipe_t num_next;
    logic              gray_sort;

    assign gray_sort = (sort_reg.den == 8'd1) && (sort_reg.dv == 8'd1) &&
                       (sort_reg.lsum != 9'd1) && (sort_reg.lsum != 9'd509);

    always_comb
    begin
        // 255 * d and 60 * mag by shift and subtract
        num_next.sat.rem  = {sort_reg.dv, 8'd0} - {8'd0, sort_reg.dv};
        num_next.sat.dsh  = {1'b0, sort_reg.den, 7'd0};
        num_next.sat.quo  = '0;
        num_next.hue.rem  = {2'd0, sort_reg.mag, 6'd0} - {6'd0, sort_reg.mag, 2'd0};
        num_next.hue.dsh  = {1'b0, sort_reg.dv, 7'd0};
        num_next.hue.quo  = '0;
        num_next.base     = sort_reg.base;
        num_next.neg      = sort_reg.neg;
        num_next.lsum     = sort_reg.lsum;
        // gray: both numerators zero so both quotients come out zero
        if (sort_reg.lsum == 9'd0 || sort_reg.mag == 8'd0)
        begin
            num_next.hue.rem = '0;
        end
        if (gray_sort)
        begin
            num_next.sat.rem = '0;
        end
    end

    assign sort_ready = !num_valid_reg || num_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_valid_reg <= 1'b0;
        end
        else if (sort_ready)
        begin
            num_valid_reg <= sort_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sort_ready && sort_valid_reg)
        begin
            num_reg <= num_next;
        end
    end

    // ---------------- stages 3 to 6: divider chain ----------------
    logic              div_valid [rgbhsl_pkg::DIV_STAGES+1];
    logic              div_ready [rgbhsl_pkg::DIV_STAGES+1];
    rgbhsl_pkg::pipe_t div_data  [rgbhsl_pkg::DIV_STAGES+1];

    assign div_valid[0] = num_valid_reg;
    assign div_data[0]  = num_reg;
    assign num_ready    = div_ready[0];

    genvar gi;
    generate
        for (gi = 0; gi < rgbhsl_pkg::DIV_STAGES; gi++)
        begin : g_div
            rgbhsl_div_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (div_valid[gi]),
                .in_ready  (div_ready[gi]),
                .in_data   (div_data[gi]),
                .out_valid (div_valid[gi+1]),
                .out_ready (div_ready[gi+1]),
                .out_data  (div_data[gi+1])
            );
        end
    endgenerate

    // ---------------- stage 7: hue fixup and output register ----------------
    rgbhsl_pkg::pipe_t div_out;
    logic              out_valid_reg;
    logic [8:0]        hue_reg;
    logic [8:0]        hue_next;
    logic [7:0]        sat_reg;
    logic [8:0]        lsum_reg;
    logic [5:0]        hue_q;
    logic              hue_frac;
    logic              out_load;

    assign div_out  = div_data[rgbhsl_pkg::DIV_STAGES];
    assign hue_q    = div_out.hue.quo[rgbhsl_pkg::HUE_Q_W-1:0];
    assign hue_frac = div_out.hue.rem != '0;

    always_comb
    begin
        // a falling difference takes the ceiling of the quotient off the base
        if (div_out.neg)
        begin
            hue_next = div_out.base - {3'd0, hue_q} - {8'd0, hue_frac};
        end
        else
        begin
            hue_next = div_out.base + {3'd0, hue_q};
        end
    end

    assign out_load = !out_valid_reg || out_ready;
    assign div_ready[rgbhsl_pkg::DIV_STAGES] = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= div_valid[rgbhsl_pkg::DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && div_valid[rgbhsl_pkg::DIV_STAGES])
        begin
            hue_reg  <= hue_next;
            sat_reg  <= div_out.sat.quo;
            lsum_reg <= div_out.lsum;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hue_deg       = hue_reg;
    assign saturation    = sat_reg;
    assign lightness_sum = lsum_reg;

`ifndef SYNTHESIS
    // hue always stays inside one turn
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue_deg < 9'd360))
        else $error("hue out of range");

    // black and white pixels are gray
    a_gray_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lightness_sum == 9'd0 || lightness_sum == 9'd510)
        |-> (saturation == 8'd0) && (hue_deg == 9'd0))
        else $error("black or white pixel with nonzero hue or saturation");

    // the input side only stalls behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");
`endif

endmodule
